// ===== design/csgsc_pkg.sv =====
// ----------------------------------------------------------------------------
// csgsc_pkg: shared types and constants for the CSG ray span combiner
// Beat structs, command and boolean-op codes, and the control/status
// bundles that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package csgsc_pkg;

  localparam int LIST_DEPTH_DEF = 16;
  localparam int DIST_W = 32;
  localparam int TAG_W = 16;
  localparam int CMD_W = 2;
  localparam int OP_W = 2;

  // input commands
  localparam logic [CMD_W-1:0] CMD_APPEND_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMBINE = 2'd2;

  // boolean ops; the unused code behaves as union
  localparam logic [OP_W-1:0] OP_UNION = 2'd0;
  localparam logic [OP_W-1:0] OP_INTER = 2'd1;
  localparam logic [OP_W-1:0] OP_DIFF = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic signed [DIST_W-1:0] hit_distance;
    logic [TAG_W-1:0] hit_tag;
  } cmd_beat_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] out_distance;
    logic [TAG_W-1:0] out_tag;
    logic out_valid;
    logic out_last;
    logic overflow;
  } res_beat_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] hit_dist;
    logic [TAG_W-1:0] tag;
  } hit_t;

  // controller -> datapath
  typedef struct packed {
    logic append_a;
    logic append_b;
    logic start;
    logic step;
    logic flush;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_done;
    logic step_blocked;
    logic out_can_load;
  } sts_t;

endpackage

// ===== design/csg_ray_span_combine.sv =====
// ----------------------------------------------------------------------------
// csg_ray_span_combine: CSG boolean merge of two ray hit lists
// Loads hits into lists A and B, then merges them under union,
// intersection or difference and streams out the kept boundary hits.
// ----------------------------------------------------------------------------
// Usage:
//   cmd (cmd_valid/cmd_ready, cmd_beat): a beat appends one hit to list A
//   or B, or asks for a combine. cfg_write_en/cfg_write_data set bool_op
//   (0 union, 1 intersection, 2 difference, 3 as union); write it only idle.
//   res (res_valid/res_ready, res_beat): kept hits in distance order, last
//   marked, or one empty beat; overflow flags appends dropped on a full list.
// Sequence:
//   Appends are taken back to back while idle. After a combine is accepted
//   cmd_ready stays low for one merge step per stored hit, for the merge
//   state seeing the walk end, and for the flush that sets the last mark.
//   A kept hit waits in a pending register until the next kept hit or the
//   flush and shows on res the cycle after. A stalled receiver holds the
//   result register and the walk stops at the next kept hit.
// Reset: lists empty, drop flag clear, bool_op union, no result pending.
// ----------------------------------------------------------------------------
module csg_ray_span_combine #(
  parameter int LIST_DEPTH = csgsc_pkg::LIST_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [csgsc_pkg::OP_W-1:0] cfg_write_data,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  csgsc_pkg::cmd_beat_t       cmd_beat,
  output logic                       res_valid,
  input  logic                       res_ready,
  output csgsc_pkg::res_beat_t       res_beat
);
  import csgsc_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // sequencer: idle/merge/flush
  csgsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .command   (cmd_beat.command),
    .sts       (sts),
    .cmd_ready (cmd_ready),
    .ctl       (ctl)
  );

  // lists, merge step and result register
  csgsc_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .cmd_beat       (cmd_beat),
    .ctl            (ctl),
    .sts            (sts),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res_beat       (res_beat)
  );

`ifndef ASSERT_OFF
  // an empty combine result is always the final beat
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_beat.out_valid |-> res_beat.out_last)
    else $error("empty result beat without last mark");

  // an empty combine result carries zero distance and tag
  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_beat.out_valid |-> res_beat.out_distance == '0 &&
      res_beat.out_tag == '0)
    else $error("empty result beat with nonzero payload");

  // the walk never steps past the end of both lists
  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    ctl.step |-> !sts.walk_done && !sts.step_blocked)
    else $error("merge step issued out of range");

  // a flush puts a beat in the result register and frees the input
  a_flush_result: assert property (@(posedge clk) disable iff (rst)
    ctl.flush |=> res_valid && res_beat.out_last && cmd_ready)
    else $error("flush without final beat");
`endif

endmodule

// ===== design/csgsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// csgsc_ctrl: sequencer for the CSG ray span combiner
// Takes command beats, runs the merge walk and the final flush.
// ----------------------------------------------------------------------------
module csgsc_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  input  logic [csgsc_pkg::CMD_W-1:0] command,
  input  csgsc_pkg::sts_t            sts,
  output logic                       cmd_ready,
  output csgsc_pkg::ctl_t            ctl
);
  import csgsc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_MERGE = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd_ready = 1'b0;
    ctl = '0;
    case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          case (command)
            CMD_APPEND_A: ctl.append_a = 1'b1;
            CMD_APPEND_B: ctl.append_b = 1'b1;
            CMD_COMBINE: begin
              ctl.start = 1'b1;
              state_next = ST_MERGE;
            end
            default: ;  // unused code: dropped silently
          endcase
        end
      end
      ST_MERGE: begin
        if (sts.walk_done) begin
          state_next = ST_FLUSH;
        end else if (!sts.step_blocked) begin
          ctl.step = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (sts.out_can_load) begin
          ctl.flush = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/csgsc_dp.sv =====
// ----------------------------------------------------------------------------
// csgsc_dp: hit lists, merge walk and result register
// Two hit memories with registered heads, the inside flags, one pending
// kept hit (so the last mark can be set) and the output register.
// ----------------------------------------------------------------------------
module csgsc_dp #(
  parameter int LIST_DEPTH = csgsc_pkg::LIST_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [csgsc_pkg::OP_W-1:0] cfg_write_data,
  input  csgsc_pkg::cmd_beat_t       cmd_beat,
  input  csgsc_pkg::ctl_t            ctl,
  output csgsc_pkg::sts_t            sts,
  output logic                       res_valid,
  input  logic                       res_ready,
  output csgsc_pkg::res_beat_t       res_beat
);
  import csgsc_pkg::*;

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W = $clog2(LIST_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

  hit_t list_a [LIST_DEPTH];
  hit_t list_b [LIST_DEPTH];
  hit_t a_head, b_head, pend_hit, sel_hit, in_hit;

  logic [CNT_W-1:0] count_a, count_b, ia, ib, ia_next, ib_next;
  logic [OP_W-1:0] bool_op;
  logic ina, inb, old_in, dropped, pend_valid, res_full;
  logic a_left, b_left, take_a, ina_n, inb_n, now_in, kept, load_out;
  logic wr_a, wr_b;

  assign in_hit = '{hit_dist: cmd_beat.hit_distance, tag: cmd_beat.hit_tag};
  assign wr_a = ctl.append_a && (count_a < DEPTH_C);
  assign wr_b = ctl.append_b && (count_b < DEPTH_C);

  // merge decision on the registered list heads; ties go to B
  assign a_left = ia < count_a;
  assign b_left = ib < count_b;
  assign take_a = a_left && (!b_left || (a_head.hit_dist < b_head.hit_dist));
  assign ina_n = ina ^ take_a;
  assign inb_n = inb ^ !take_a;
  assign sel_hit = take_a ? a_head : b_head;

  always_comb begin
    case (bool_op)
      OP_INTER: now_in = ina_n & inb_n;
      OP_DIFF:  now_in = ina_n & ~inb_n;
      default:  now_in = ina_n | inb_n;
    endcase
  end

  assign kept = now_in != old_in;

  assign sts.walk_done = !a_left && !b_left;
  assign sts.out_can_load = !res_full || res_ready;
  assign sts.step_blocked = kept && pend_valid && !sts.out_can_load;

  assign load_out = (ctl.step && kept && pend_valid) || ctl.flush;

  always_comb begin
    ia_next = ia;
    ib_next = ib;
    if (ctl.start) begin
      ia_next = '0;
      ib_next = '0;
    end else if (ctl.step) begin
      if (take_a) begin
        ia_next = ia + CNT_W'(1);
      end else begin
        ib_next = ib + CNT_W'(1);
      end
    end
  end

  // hit memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (wr_a) begin
      list_a[count_a[IDX_W-1:0]] <= in_hit;
    end
    if (wr_b) begin
      list_b[count_b[IDX_W-1:0]] <= in_hit;
    end
    a_head <= list_a[ia_next[IDX_W-1:0]];
    b_head <= list_b[ib_next[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_a <= '0;
      count_b <= '0;
      dropped <= 1'b0;
      bool_op <= OP_UNION;
      ia <= '0;
      ib <= '0;
      ina <= 1'b0;
      inb <= 1'b0;
      old_in <= 1'b0;
      pend_valid <= 1'b0;
      res_full <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        bool_op <= cfg_write_data;
      end
      if (wr_a) begin
        count_a <= count_a + CNT_W'(1);
      end
      if (wr_b) begin
        count_b <= count_b + CNT_W'(1);
      end
      if ((ctl.append_a && !wr_a) || (ctl.append_b && !wr_b)) begin
        dropped <= 1'b1;
      end
      ia <= ia_next;
      ib <= ib_next;
      if (ctl.start) begin
        ina <= 1'b0;
        inb <= 1'b0;
        old_in <= 1'b0;
        pend_valid <= 1'b0;
      end else if (ctl.step) begin
        ina <= ina_n;
        inb <= inb_n;
        old_in <= now_in;
        if (kept) begin
          pend_valid <= 1'b1;
        end
      end
      if (ctl.flush) begin
        count_a <= '0;
        count_b <= '0;
        dropped <= 1'b0;
        pend_valid <= 1'b0;
      end
      if (load_out) begin
        res_full <= 1'b1;
      end else if (res_ready) begin
        res_full <= 1'b0;
      end
    end
  end

  // pending hit and result payload
  always_ff @(posedge clk) begin
    if (ctl.step && kept) begin
      pend_hit <= sel_hit;
    end
    if (ctl.flush) begin
      res_beat.out_distance <= pend_valid ? pend_hit.hit_dist : '0;
      res_beat.out_tag <= pend_valid ? pend_hit.tag : '0;
      res_beat.out_valid <= pend_valid;
      res_beat.out_last <= 1'b1;
      res_beat.overflow <= dropped;
    end else if (load_out) begin
      res_beat.out_distance <= pend_hit.hit_dist;
      res_beat.out_tag <= pend_hit.tag;
      res_beat.out_valid <= 1'b1;
      res_beat.out_last <= 1'b0;
      res_beat.overflow <= dropped;
    end
  end

  assign res_valid = res_full;

endmodule

// ===== bench/csg_ray_span_combine_tb.sv =====
// ----------------------------------------------------------------------------
// csg_ray_span_combine_tb: self-checking bench for the CSG ray span combiner
// Sends hit appends and combine commands over the command channel and keeps
// its own merge model of both hit lists. It checks every result beat, field
// by field, against the predicted span boundaries under each boolean op.
// ----------------------------------------------------------------------------
module csg_ray_span_combine_tb;
  import csgsc_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int DEPTH = LIST_DEPTH_DEF;
  // a combine walks at most both full lists plus accept and flush cycles
  localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
  localparam int DRAIN_LIMIT = 20000;
  localparam int WATCHDOG_TIME = 3000000;
  localparam int RANDOM_PHASE_BEATS = 30;
  localparam int CALM_BEATS = 40;

  // codes the package leaves unnamed: command 3 is ignored, op 3 acts as union
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [OP_W-1:0] OP_AS_UNION = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [OP_W-1:0] cfg_write_data = '0;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_beat_t cmd_beat = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_beat_t res_beat;

  csg_ray_span_combine dut (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd_beat(cmd_beat),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_beat(res_beat)
  );

  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Span model: our own copy of both hit lists, the drop flag and the op.
  // Each accepted command beat is applied here; a combine queues the beats
  // the block must return onto expected_spans.
  // --------------------------------------------------------------------------
  hit_t span_list_a [DEPTH];
  hit_t span_list_b [DEPTH];
  int span_count_a = 0;
  int span_count_b = 0;
  logic span_dropped = 1'b0;
  logic [OP_W-1:0] span_op = OP_UNION;   // reset value of bool_op
  res_beat_t expected_spans [$];

  // run statistics
  int mismatches = 0;
  int beats_sent = 0;
  int combines_sent = 0;
  int results_checked = 0;
  int overflow_beats = 0;
  int empty_beats = 0;

  // when set, neither side idles
  bit calm_stretch = 1'b0;

  function automatic void queue_span(res_beat_t r);
    expected_spans.insert(expected_spans.size(), r);
  endfunction

  function automatic void apply_command(cmd_beat_t b);
    hit_t h;
    hit_t pick;
    res_beat_t r;
    res_beat_t pend_span;
    int ia;
    int ib;
    int kept;
    logic ina;
    logic inb;
    logic was_in;
    logic now_in;
    logic take_a;
    h.hit_dist = b.hit_distance;
    h.tag = b.hit_tag;
    case (b.command)
      CMD_APPEND_A: begin
        if (span_count_a < DEPTH) begin
          span_list_a[span_count_a] = h;
          span_count_a++;
        end else begin
          span_dropped = 1'b1;
        end
      end
      CMD_APPEND_B: begin
        if (span_count_b < DEPTH) begin
          span_list_b[span_count_b] = h;
          span_count_b++;
        end else begin
          span_dropped = 1'b1;
        end
      end
      CMD_COMBINE: begin
        ia = 0;
        ib = 0;
        kept = 0;
        ina = 1'b0;
        inb = 1'b0;
        was_in = 1'b0;
        pend_span = '0;
        // merge walk; on equal distance the B hit is taken first
        while (ia < span_count_a || ib < span_count_b) begin
          take_a = 1'b0;
          if (ia < span_count_a) begin
            if (ib >= span_count_b) begin
              take_a = 1'b1;
            end else if ($signed(span_list_a[ia].hit_dist) <
                         $signed(span_list_b[ib].hit_dist)) begin
              take_a = 1'b1;
            end
          end
          if (take_a) begin
            pick = span_list_a[ia];
            ia++;
            ina = ~ina;
          end else begin
            pick = span_list_b[ib];
            ib++;
            inb = ~inb;
          end
          case (span_op)
            OP_INTER: now_in = ina & inb;
            OP_DIFF: now_in = ina & ~inb;
            default: now_in = ina | inb;
          endcase
          // a boundary of the combined solid is a kept hit; the latest one
          // is held back so the last mark can go on it
          if (now_in != was_in) begin
            if (kept != 0) queue_span(pend_span);
            pend_span.out_distance = pick.hit_dist;
            pend_span.out_tag = pick.tag;
            pend_span.out_valid = 1'b1;
            pend_span.out_last = 1'b0;
            pend_span.overflow = span_dropped;
            kept++;
          end
          was_in = now_in;
        end
        if (kept == 0) begin
          r = '0;
          r.out_last = 1'b1;
          r.overflow = span_dropped;
          queue_span(r);
        end else begin
          pend_span.out_last = 1'b1;
          queue_span(pend_span);
        end
        span_count_a = 0;
        span_count_b = 0;
        span_dropped = 1'b0;
      end
      default: begin
        // unused command: no result, no state change
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Result checker: every accepted result beat against the oldest expected.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    res_beat_t want;
    if (!rst && res_valid && res_ready) begin
      results_checked++;
      if (res_beat.overflow) overflow_beats++;
      if (!res_beat.out_valid) empty_beats++;
      if (expected_spans.size() == 0) begin
        report_mismatch("result beat with none expected", res_beat, 0);
      end else begin
        want = expected_spans.pop_front();
        if (res_beat.out_distance !== want.out_distance)
          report_mismatch("out_distance", res_beat.out_distance, want.out_distance);
        if (res_beat.out_tag !== want.out_tag)
          report_mismatch("out_tag", res_beat.out_tag, want.out_tag);
        if (res_beat.out_valid !== want.out_valid)
          report_mismatch("out_valid", res_beat.out_valid, want.out_valid);
        if (res_beat.out_last !== want.out_last)
          report_mismatch("out_last", res_beat.out_last, want.out_last);
        if (res_beat.overflow !== want.overflow)
          report_mismatch("overflow", res_beat.overflow, want.overflow);
      end
    end
  end

  // receiver backpressure: stalls about one cycle in ten unless calm
  always @(posedge clk) begin
    res_ready <= calm_stretch || ($urandom_range(0, 99) >= 10);
  end

  // --------------------------------------------------------------------------
  // Sender side. send_beat leaves cmd_valid high after the beat is taken so
  // back-to-back beats need no second assignment in one step; hold_sender
  // lowers it and waits on the clock before anything else waits.
  // --------------------------------------------------------------------------
  task automatic send_beat(input logic [CMD_W-1:0] command,
                           input logic [DIST_W-1:0] dist_val,
                           input logic [TAG_W-1:0] tag);
    cmd_beat_t b;
    int gap;
    b.command = command;
    b.hit_distance = dist_val;
    b.hit_tag = tag;
    if (!calm_stretch && $urandom_range(0, 99) < 10) begin
      gap = $urandom_range(1, 4);
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_beat <= b;
    do @(posedge clk); while (!cmd_ready);
    apply_command(b);
    if (command != CMD_UNUSED) beats_sent++;
    if (command == CMD_COMBINE) combines_sent++;
  endtask

  task automatic hold_sender();
    cmd_valid <= 1'b0;
    @(posedge clk);
  endtask

  // sender pauses until every expected beat is back, then lets the walk settle
  task automatic wait_for_results();
    int waited;
    hold_sender();
    waited = 0;
    while (expected_spans.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_spans.size() != 0) begin
      report_mismatch("expected beats never returned", expected_spans.size(), 0);
      expected_spans.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic write_bool_op(input logic [OP_W-1:0] op);
    cfg_write_en <= 1'b1;
    cfg_write_data <= op;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    span_op = op;
    @(posedge clk);
  endtask

  function automatic int random_distance();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return $signed($urandom());
    // tight cluster so A and B hits tie often
    if (roll < 70) return $urandom_range(0, 15) - 8;
    return $urandom_range(0, 200 << 16) - (100 << 16);
  endfunction

  // one load-and-combine sequence: mostly sorted lists, sometimes unsorted,
  // sometimes overfull, now and then noise or a missing combine
  task automatic send_random_sequence();
    int na;
    int nb;
    int ia;
    int ib;
    int i;
    int da [$];
    int db [$];
    if ($urandom_range(0, 99) < 8) begin
      na = $urandom_range(DEPTH - 4, DEPTH + 2);
      nb = $urandom_range(DEPTH - 4, DEPTH + 2);
    end else begin
      na = $urandom_range(0, 6);
      nb = $urandom_range(0, 6);
    end
    for (i = 0; i < na; i++) da.insert(da.size(), random_distance());
    for (i = 0; i < nb; i++) db.insert(db.size(), random_distance());
    if ($urandom_range(0, 99) >= 10) begin
      da.sort();
      db.sort();
    end
    ia = 0;
    ib = 0;
    while (ia < na || ib < nb) begin
      if (ia < na && (ib >= nb || $urandom_range(0, 1) == 1)) begin
        send_beat(CMD_APPEND_A, da[ia], TAG_W'($urandom_range(0, 65535)));
        ia++;
      end else begin
        send_beat(CMD_APPEND_B, db[ib], TAG_W'($urandom_range(0, 65535)));
        ib++;
      end
      if ($urandom_range(0, 99) < 4)
        send_beat(CMD_UNUSED, $urandom(), TAG_W'($urandom_range(0, 65535)));
    end
    // a broken sequence: lists carry over into the next one
    if ($urandom_range(0, 99) >= 5)
      send_beat(CMD_COMBINE, $urandom(), TAG_W'($urandom_range(0, 65535)));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // bool_op left at its reset value: union
  task automatic test_union_extremes();
    send_beat(CMD_COMBINE, 32'h0, 16'h0);   // nothing loaded: empty beat
    send_beat(CMD_APPEND_A, 32'h8000_0000, 16'hFFFF);
    send_beat(CMD_APPEND_A, 32'h7FFF_FFFF, 16'h0000);
    send_beat(CMD_APPEND_B, 32'h0000_0000, 16'h1234);
    send_beat(CMD_APPEND_B, 32'h0001_0000, 16'hABCD);
    send_beat(CMD_COMBINE, 32'hFFFF_FFFF, 16'hFFFF);
  endtask

  // equal distances go B first; the unused command does nothing
  task automatic test_ties_and_ignored();
    send_beat(CMD_APPEND_A, 32'h0000_0100, 16'h0001);
    send_beat(CMD_APPEND_B, 32'h0000_0100, 16'h0002);
    send_beat(CMD_APPEND_A, 32'h0000_0200, 16'h0003);
    send_beat(CMD_APPEND_B, 32'h0000_0200, 16'h0004);
    send_beat(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
    send_beat(CMD_COMBINE, 32'h0, 16'h0);
    send_beat(CMD_UNUSED, 32'h5555_AAAA, 16'h5A5A);
    send_beat(CMD_COMBINE, 32'h0, 16'h0);
  endtask

  task automatic test_op_settings();
    wait_for_results();
    write_bool_op(OP_INTER);
    // unsorted lists are walked as given
    send_beat(CMD_APPEND_A, 32'h0000_0500, 16'h0A00);
    send_beat(CMD_APPEND_A, 32'h0000_0100, 16'h0A01);
    send_beat(CMD_APPEND_B, 32'h0000_0300, 16'h0B00);
    send_beat(CMD_APPEND_B, 32'h0000_0050, 16'h0B01);
    send_beat(CMD_COMBINE, 32'h0, 16'h0);
    wait_for_results();
    write_bool_op(OP_DIFF);
    send_beat(CMD_APPEND_A, 32'hFFFD_0000, 16'h1A00);
    send_beat(CMD_APPEND_A, 32'h0003_0000, 16'h1A01);
    send_beat(CMD_APPEND_B, 32'hFFFF_0000, 16'h1B00);
    send_beat(CMD_APPEND_B, 32'h0001_0000, 16'h1B01);
    send_beat(CMD_COMBINE, 32'h0, 16'h0);
    wait_for_results();
    write_bool_op(OP_AS_UNION);
    send_beat(CMD_APPEND_A, 32'h0000_1000, 16'h2A00);
    send_beat(CMD_APPEND_B, 32'h0000_2000, 16'h2B00);
    send_beat(CMD_COMBINE, 32'h0, 16'h0);
  endtask

  // one append past a full list A is dropped and flags overflow
  task automatic test_full_list();
    int i;
    wait_for_results();
    write_bool_op(OP_UNION);
    for (i = 0; i <= DEPTH; i++)
      send_beat(CMD_APPEND_A, i << 16, TAG_W'(32'hC000 + i));
    send_beat(CMD_APPEND_B, 32'h0002_8000, 16'hD000);
    send_beat(CMD_COMBINE, 32'h0, 16'h0);
  endtask

  // random sequences in five phases over all four ops, each phase starting from idle
  task automatic test_random_spans();
    logic [OP_W-1:0] phase_op [5];
    int phase;
    int target;
    phase_op[0] = OP_UNION;
    phase_op[1] = OP_INTER;
    phase_op[2] = OP_DIFF;
    phase_op[3] = OP_AS_UNION;
    phase_op[4] = OP_INTER;
    for (phase = 0; phase < 5; phase++) begin
      wait_for_results();
      write_bool_op(phase_op[phase]);
      target = beats_sent + RANDOM_PHASE_BEATS;
      while (beats_sent < target) send_random_sequence();
    end
  endtask

  // long stretch with neither side idling
  task automatic test_calm_stretch();
    int target;
    wait_for_results();
    write_bool_op(OP_DIFF);
    calm_stretch = 1'b1;
    target = beats_sent + CALM_BEATS;
    while (beats_sent < target) send_random_sequence();
    wait_for_results();
    calm_stretch = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_union_extremes();
    test_ties_and_ignored();
    test_op_settings();
    test_full_list();
    test_random_spans();
    test_calm_stretch();
    wait_for_results();
    $display("Covered %0d command beats, %0d combines, all four bool_op codes.",
             beats_sent, combines_sent);
    $display("Checked %0d result beats: %0d empty, %0d with overflow set.",
             results_checked, empty_beats, overflow_beats);
    if (mismatches == 0) begin
      $display("csg_ray_span_combine regression: pass");
    end else begin
      $display("csg_ray_span_combine regression: fail");
    end
    $finish;
  end

  initial begin
    #WATCHDOG_TIME;
    $display("Timeout with %0d result beats outstanding.", expected_spans.size());
    $display("csg_ray_span_combine regression: fail");
    $finish;
  end

endmodule
